// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/bcd_pkg.sv -----
// Types and constants of the block cache directory.
package bcd_pkg;

    localparam int DEVICE_COUNT = 16;
    localparam int RESULT_LIMIT = 64;
    localparam int WB_CNT_W     = $clog2(RESULT_LIMIT + 1);
    localparam int SLOT_W       = 6;
    localparam int IN_DATA_W    = 72;
    localparam int OUT_DATA_W   = 144;
    localparam int OUT_PAD_W    = 4;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_FLUSH = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_FIN  = 2'd2
    } t_state;

    typedef struct packed {
        logic [3:0]  device;
        logic [31:0] block;
        logic [31:0] buffer;
    } t_entry;

    typedef struct packed {
        logic [31:0]       miss_total;
        logic [31:0]       hit_total;
        logic [31:0]       writeback_buffer;
        logic [31:0]       writeback_block;
        logic              writeback_valid;
        logic              marked_dirty;
        logic              filled;
        logic [SLOT_W-1:0] slot;
        logic              served_from_cache;
        logic              hit;
        logic              rejected;
    } t_result;

endpackage

// ----- hw/rtl/block_cache_directory.sv -----
// Block cache directory: fully associative tag directory with scan sequencer.
//
// Input channel s_axis: one transfer per request. tuser carries the kind (read lookup,
// write mark, flush device, clear directory); tdata carries device, block, buffer and
// the single-block and read-ok flags. Output channel m_axis: result transfers, tlast
// on the final result of each request.
// Read and write scan the directory one entry per clock through a single tag compare
// behind a registered memory port; a flush scans the entries and yields one transfer
// per dirty entry of the device, up to RESULT_LIMIT, or a single empty one. Reject and
// clear skip the scan; a read or write scan ends early on a tag match. The next request
// is taken once the final result sits in the output register, so requests do not
// overlap; the single memory read port and the shared compare pace the scan.
// Reset clears all valid and dirty marks and both counters at once; no clearing pass.
// A stalled receiver holds the output register; a flush then pauses its scan until the
// waiting transfer is taken.
`include "assert_macros.svh"

module block_cache_directory #(
    parameter int CACHE_ENTRIES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // device_id[3:0], block_number[35:4], buffer_address[67:36], single_block[68],
    // device_read_ok[69], zero pad
    input  logic [bcd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // rejected[0], hit[1], served_from_cache[2], slot[8:3], filled[9],
    // marked_dirty[10], writeback_valid[11], writeback_block[43:12],
    // writeback_buffer[75:44], hit_total[107:76], miss_total[139:108], zero pad
    output logic [bcd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast
);

    localparam int IW = $clog2(CACHE_ENTRIES);
    localparam int CW = $clog2(CACHE_ENTRIES + 1);

    bcd_pkg::t_entry              mem [CACHE_ENTRIES];
    bcd_pkg::t_entry              r_rd_data;

    bcd_pkg::t_state              r_state, n_state;
    logic [CACHE_ENTRIES-1:0]     r_valid, n_valid;
    logic [CACHE_ENTRIES-1:0]     r_dirty, n_dirty;
    logic [31:0]                  r_hit, n_hit;
    logic [31:0]                  r_miss, n_miss;
    logic [IW-1:0]                r_fill_ptr, n_fill_ptr;
    logic                         r_out_vld, n_out_vld;
    logic [CW-1:0]                r_idx, n_idx;
    logic                         r_cmp_vld, n_cmp_vld;
    logic                         r_pend_vld, n_pend_vld;
    logic [bcd_pkg::WB_CNT_W-1:0] r_wb_cnt, n_wb_cnt;
    logic                         r_found, n_found;

    bcd_pkg::t_kind               r_kind, n_kind;
    logic [3:0]                   r_dev, n_dev;
    logic [31:0]                  r_blk, n_blk;
    logic [31:0]                  r_buf, n_buf;
    logic                         r_single, n_single;
    logic                         r_read_ok, n_read_ok;
    logic                         r_reject, n_reject;
    logic [IW-1:0]                r_found_idx, n_found_idx;
    logic [IW-1:0]                r_cmp_idx, n_cmp_idx;
    bcd_pkg::t_result             r_pend, n_pend;
    bcd_pkg::t_result             r_out, n_out;
    logic                         r_out_last, n_out_last;

    logic                         mem_re;
    logic                         mem_we;
    logic [IW-1:0]                mem_waddr;
    bcd_pkg::t_entry              mem_wdata;

    logic                         out_free;
    logic                         dev_match;
    logic                         tag_hit;
    logic                         flush_hit;
    logic                         stall;
    logic                         in_known;
    bcd_pkg::t_kind               in_kind;
    bcd_pkg::t_result             res;
    logic [bcd_pkg::WB_CNT_W-1:0] wb_cnt_inc;

    assign out_free   = !r_out_vld || m_axis_tready;
    assign dev_match  = r_valid[r_cmp_idx] && (r_rd_data.device == r_dev);
    assign tag_hit    = dev_match && (r_rd_data.block == r_blk);
    assign flush_hit  = dev_match && r_dirty[r_cmp_idx];
    assign stall      = r_cmp_vld && (r_kind == bcd_pkg::KIND_FLUSH) && flush_hit
                        && r_pend_vld && !out_free;
    assign in_known   = int'(s_axis_tdata[3:0]) < bcd_pkg::DEVICE_COUNT;
    assign in_kind    = bcd_pkg::t_kind'(s_axis_tuser);
    assign wb_cnt_inc = r_wb_cnt + 1'b1;

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{bcd_pkg::OUT_PAD_W{1'b0}}, r_out};
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_dirty     = r_dirty;
        n_hit       = r_hit;
        n_miss      = r_miss;
        n_fill_ptr  = r_fill_ptr;
        n_out_vld   = r_out_vld && !m_axis_tready;
        n_idx       = r_idx;
        n_cmp_vld   = r_cmp_vld;
        n_pend_vld  = r_pend_vld;
        n_wb_cnt    = r_wb_cnt;
        n_found     = r_found;
        n_kind      = r_kind;
        n_dev       = r_dev;
        n_blk       = r_blk;
        n_buf       = r_buf;
        n_single    = r_single;
        n_read_ok   = r_read_ok;
        n_reject    = r_reject;
        n_found_idx = r_found_idx;
        n_cmp_idx   = r_cmp_idx;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_last  = r_out_last;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_fill_ptr;
        mem_wdata   = '{device: r_dev, block: r_blk, buffer: r_buf};
        res         = '0;
        s_axis_tready = 1'b0;

        unique case (r_state)
            bcd_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_kind     = in_kind;
                    n_dev      = s_axis_tdata[3:0];
                    n_blk      = s_axis_tdata[35:4];
                    n_buf      = s_axis_tdata[67:36];
                    n_single   = s_axis_tdata[68];
                    n_read_ok  = s_axis_tdata[69];
                    n_reject   = ((in_kind == bcd_pkg::KIND_READ)
                                  || (in_kind == bcd_pkg::KIND_WRITE))
                                 && (!in_known || (s_axis_tdata[67:36] == 32'd0));
                    n_idx      = '0;
                    n_cmp_vld  = 1'b0;
                    n_pend_vld = 1'b0;
                    n_wb_cnt   = '0;
                    n_found    = 1'b0;
                    if (in_kind == bcd_pkg::KIND_CLEAR) begin
                        n_valid = '0;
                        n_dirty = '0;
                        n_state = bcd_pkg::S_FIN;
                    end else if (n_reject || !in_known) begin
                        n_state = bcd_pkg::S_FIN;
                    end else begin
                        n_state = bcd_pkg::S_SCAN;
                    end
                end
            end
            bcd_pkg::S_SCAN: begin
                if (!stall) begin
                    if (r_idx != CW'(CACHE_ENTRIES)) begin
                        mem_re    = 1'b1;
                        n_cmp_idx = r_idx[IW-1:0];
                        n_cmp_vld = 1'b1;
                        n_idx     = r_idx + 1'b1;
                    end else begin
                        n_cmp_vld = 1'b0;
                    end
                    if (r_cmp_vld) begin
                        if (r_kind == bcd_pkg::KIND_FLUSH) begin
                            if (flush_hit) begin
                                n_dirty[r_cmp_idx] = 1'b0;
                                if (r_pend_vld) begin
                                    n_out      = r_pend;
                                    n_out_last = 1'b0;
                                    n_out_vld  = 1'b1;
                                end
                                res.slot             = bcd_pkg::SLOT_W'(r_cmp_idx);
                                res.writeback_valid  = 1'b1;
                                res.writeback_block  = r_rd_data.block;
                                res.writeback_buffer = r_rd_data.buffer;
                                res.hit_total        = r_hit;
                                res.miss_total       = r_miss;
                                n_pend     = res;
                                n_pend_vld = 1'b1;
                                n_wb_cnt   = wb_cnt_inc;
                                if (wb_cnt_inc == bcd_pkg::WB_CNT_W'(bcd_pkg::RESULT_LIMIT))
                                begin
                                    n_state = bcd_pkg::S_FIN;
                                end
                            end
                        end else if (tag_hit) begin
                            n_found     = 1'b1;
                            n_found_idx = r_cmp_idx;
                            if (r_kind == bcd_pkg::KIND_WRITE) begin
                                n_dirty[r_cmp_idx] = 1'b1;
                            end
                            n_state = bcd_pkg::S_FIN;
                        end
                    end else if (r_idx == CW'(CACHE_ENTRIES)) begin
                        n_state = bcd_pkg::S_FIN;
                    end
                end
            end
            bcd_pkg::S_FIN: begin
                if (out_free) begin
                    res.hit_total  = r_hit;
                    res.miss_total = r_miss;
                    priority if (r_reject) begin
                        res.rejected = 1'b1;
                    end else if (r_kind == bcd_pkg::KIND_FLUSH) begin
                        if (r_pend_vld) begin
                            res = r_pend;
                        end
                    end else if (r_kind == bcd_pkg::KIND_WRITE) begin
                        if (r_found) begin
                            res.marked_dirty = 1'b1;
                            res.slot         = bcd_pkg::SLOT_W'(r_found_idx);
                        end
                    end else if (r_kind == bcd_pkg::KIND_READ) begin
                        if (r_found) begin
                            n_hit    = r_hit + 32'd1;
                            res.hit  = 1'b1;
                            res.slot = bcd_pkg::SLOT_W'(r_found_idx);
                        end
                        if (r_found && r_single) begin
                            res.served_from_cache = 1'b1;
                        end else begin
                            n_miss = r_miss + 32'd1;
                            if ((r_miss == '1) || (r_fill_ptr == IW'(CACHE_ENTRIES - 1))) begin
                                n_fill_ptr = '0;
                            end else begin
                                n_fill_ptr = r_fill_ptr + 1'b1;
                            end
                            if (r_read_ok && r_single) begin
                                mem_we              = 1'b1;
                                mem_waddr           = n_fill_ptr;
                                n_valid[n_fill_ptr] = 1'b1;
                                n_dirty[n_fill_ptr] = 1'b0;
                                res.filled          = 1'b1;
                                res.slot            = bcd_pkg::SLOT_W'(n_fill_ptr);
                            end
                        end
                        res.hit_total  = n_hit;
                        res.miss_total = n_miss;
                    end else begin
                        res = res;
                    end
                    n_out      = res;
                    n_out_last = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = bcd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bcd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bcd_pkg::S_IDLE;
            r_valid    <= '0;
            r_dirty    <= '0;
            r_hit      <= '0;
            r_miss     <= '0;
            r_fill_ptr <= '0;
            r_out_vld  <= 1'b0;
            r_idx      <= '0;
            r_cmp_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_wb_cnt   <= '0;
            r_found    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_dirty    <= n_dirty;
            r_hit      <= n_hit;
            r_miss     <= n_miss;
            r_fill_ptr <= n_fill_ptr;
            r_out_vld  <= n_out_vld;
            r_idx      <= n_idx;
            r_cmp_vld  <= n_cmp_vld;
            r_pend_vld <= n_pend_vld;
            r_wb_cnt   <= n_wb_cnt;
            r_found    <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_dev       <= n_dev;
        r_blk       <= n_blk;
        r_buf       <= n_buf;
        r_single    <= n_single;
        r_read_ok   <= n_read_ok;
        r_reject    <= n_reject;
        r_found_idx <= n_found_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_pend      <= n_pend;
        r_out       <= n_out;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[r_idx[IW-1:0]];
        end
    end

    `ASSERT_CLK(a_partial_only_flush, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tlast) |-> (r_kind == bcd_pkg::KIND_FLUSH))
    `ASSERT_CLK(a_pend_counted, i_clk, i_rst_n,
        ((r_state == bcd_pkg::S_SCAN) && r_pend_vld) |-> (r_wb_cnt != '0))
    `ASSERT_CLK(a_fill_ptr_range, i_clk, i_rst_n,
        32'(r_fill_ptr) < 32'(CACHE_ENTRIES))
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, r_state != bcd_pkg::S_IDLE)

endmodule
